// ===== rtl/sobb_pkg.sv =====
// ----------------------------------------------------------------------------
// sobb_pkg
// Shared constants and width helpers for the segment versus oriented box
// overlap pipeline.
// ----------------------------------------------------------------------------
package sobb_pkg;

  localparam int FIELD_W  = 48;
  localparam int RADIUS_W = 15;
  localparam int N_AXES   = 3;

  // Axis pairs used by the edge tests.
  localparam int EDGE_P [N_AXES] = '{1, 0, 0};
  localparam int EDGE_Q [N_AXES] = '{2, 2, 1};

  // Width of a projected sum: three (2W+2)-bit products added together.
  function automatic int sum_w(input int w);
    return 2 * w + 4;
  endfunction

  // Width of an extent plus the radius.
  function automatic int ext_w(input int w);
    return ((w > 16) ? w : 16) + 1;
  endfunction

  // Width of the enlarged extent brought to the scale of the projections.
  function automatic int scale_w(input int w);
    return ext_w(w) + w - 1;
  endfunction

endpackage

// ===== rtl/sobb_wmul.sv =====
// ----------------------------------------------------------------------------
// sobb_wmul
// Signed multiplier split into four half-width partial products, with three
// register stages: partial products, pairwise sums, final sum.
// ----------------------------------------------------------------------------
module sobb_wmul #(
  parameter int AW = 36,
  parameter int BW = 36,
  localparam int OW = AW + BW
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic signed [OW-1:0] p
);

  localparam int HA  = AW / 2;
  localparam int HB  = BW / 2;
  localparam int LLW = HA + HB + 2;
  localparam int LHW = HA + BW - HB + 1;
  localparam int HLW = AW - HA + HB + 1;
  localparam int HHW = AW - HA + BW - HB;

  logic signed [HA:0]      a_lo;
  logic signed [AW-HA-1:0] a_hi;
  logic signed [HB:0]      b_lo;
  logic signed [BW-HB-1:0] b_hi;

  logic signed [HA+HB+1:0]        ll;
  logic signed [HA+BW-HB:0]       lh;
  logic signed [AW-HA+HB:0]       hl;
  logic signed [AW-HA+BW-HB-1:0]  hh;
  logic signed [OW-1:0]           t0;
  logic signed [OW-1:0]           t1;

  // The low halves are unsigned digits; the high halves carry the sign.
  assign a_lo = signed'({1'b0, a[HA-1:0]});
  assign a_hi = a[AW-1:HA];
  assign b_lo = signed'({1'b0, b[HB-1:0]});
  assign b_hi = b[BW-1:HB];

  always_ff @(posedge clk) begin
    if (en) begin
      ll <= LLW'(a_lo) * LLW'(b_lo);
      lh <= LHW'(a_lo) * LHW'(b_hi);
      hl <= HLW'(a_hi) * HLW'(b_lo);
      hh <= HHW'(a_hi) * HHW'(b_hi);
      t0 <= OW'(ll) + (OW'(lh) <<< HB);
      t1 <= OW'(hl) + (OW'(hh) <<< HB);
      p  <= t0 + (t1 <<< HA);
    end
  end

endmodule

// ===== rtl/sobb_front.sv =====
// ----------------------------------------------------------------------------
// sobb_front
// Moves the segment into the box frame: doubled midpoint offset and doubled
// half vector, their projections on the three box axes, the scaled enlarged
// extents and the magnitudes of the projections. Four register stages.
// ----------------------------------------------------------------------------
module sobb_front #(
  parameter int COORD_WIDTH = 16,
  localparam int PW = sobb_pkg::sum_w(COORD_WIDTH),
  localparam int VW = sobb_pkg::scale_w(COORD_WIDTH)
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic [sobb_pkg::FIELD_W-1:0]    seg_start,
  input  logic [sobb_pkg::FIELD_W-1:0]    seg_end,
  input  logic [sobb_pkg::RADIUS_W-1:0]   seg_radius,
  input  logic [sobb_pkg::FIELD_W-1:0]    box_center,
  input  logic [sobb_pkg::FIELD_W-1:0]    box_half_extents,
  input  logic [sobb_pkg::FIELD_W-1:0]    box_axis_x,
  input  logic [sobb_pkg::FIELD_W-1:0]    box_axis_y,
  input  logic [sobb_pkg::FIELD_W-1:0]    box_axis_z,
  output logic signed [PW-1:0]            sm [sobb_pkg::N_AXES],
  output logic signed [PW-1:0]            sd [sobb_pkg::N_AXES],
  output logic signed [PW-1:0]            am [sobb_pkg::N_AXES],
  output logic signed [PW-1:0]            ad [sobb_pkg::N_AXES],
  output logic signed [VW-1:0]            v  [sobb_pkg::N_AXES]
);

  localparam int N      = sobb_pkg::N_AXES;
  localparam int W      = COORD_WIDTH;
  localparam int PACK_W = 3 * W;
  localparam int XW     = sobb_pkg::FIELD_W + PACK_W;
  localparam int MW     = W + 2;
  localparam int EW     = sobb_pkg::ext_w(COORD_WIDTH);
  localparam int PRW    = W + MW;

  // Fields are zero-extended so that components past the top bit read as zero.
  logic [XW-1:0] x_s, x_e, x_c, x_h;
  logic [XW-1:0] x_a [N];

  logic signed [W-1:0]  c_s [N];
  logic signed [W-1:0]  c_e [N];
  logic signed [W-1:0]  c_c [N];
  logic signed [W-1:0]  c_h [N];
  logic signed [W-1:0]  c_ax [N][N];

  logic signed [MW-1:0] m2_next [N];
  logic signed [MW-1:0] d2_next [N];
  logic signed [EW-1:0] er_next [N];

  // Stage 1
  logic signed [MW-1:0] m2 [N];
  logic signed [MW-1:0] d2 [N];
  logic signed [EW-1:0] er1 [N];
  logic signed [W-1:0]  ax [N][N];
  // Stage 2
  logic signed [PRW-1:0] pm [N][N];
  logic signed [PRW-1:0] pd [N][N];
  logic signed [EW-1:0]  er2 [N];
  // Stage 3
  logic signed [PW-1:0] sm3 [N];
  logic signed [PW-1:0] sd3 [N];
  logic signed [VW-1:0] v3 [N];

  assign x_s    = {{PACK_W{1'b0}}, seg_start};
  assign x_e    = {{PACK_W{1'b0}}, seg_end};
  assign x_c    = {{PACK_W{1'b0}}, box_center};
  assign x_h    = {{PACK_W{1'b0}}, box_half_extents};
  assign x_a[0] = {{PACK_W{1'b0}}, box_axis_x};
  assign x_a[1] = {{PACK_W{1'b0}}, box_axis_y};
  assign x_a[2] = {{PACK_W{1'b0}}, box_axis_z};

  for (genvar i = 0; i < N; i++) begin : g_comp
    assign c_s[i] = x_s[i*W +: W];
    assign c_e[i] = x_e[i*W +: W];
    assign c_c[i] = x_c[i*W +: W];
    assign c_h[i] = x_h[i*W +: W];
    for (genvar a = 0; a < N; a++) begin : g_axis
      assign c_ax[a][i] = x_a[a][i*W +: W];
    end

    // The midpoint is kept doubled so that the factor one half never rounds.
    assign m2_next[i] = MW'(c_s[i]) + MW'(c_e[i]) - (MW'(c_c[i]) <<< 1);
    assign d2_next[i] = MW'(c_e[i]) - MW'(c_s[i]);
    assign er_next[i] = EW'(c_h[i]) + EW'(signed'({1'b0, seg_radius}));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < N; i++) begin
        m2[i]  <= m2_next[i];
        d2[i]  <= d2_next[i];
        er1[i] <= er_next[i];
        for (int a = 0; a < N; a++) begin
          ax[a][i] <= c_ax[a][i];
        end
      end

      for (int a = 0; a < N; a++) begin
        er2[a] <= er1[a];
        for (int i = 0; i < N; i++) begin
          pm[a][i] <= PRW'(ax[a][i]) * PRW'(m2[i]);
          pd[a][i] <= PRW'(ax[a][i]) * PRW'(d2[i]);
        end
      end

      // The extent scale matches the doubled offsets times the axis fraction.
      for (int a = 0; a < N; a++) begin
        sm3[a] <= PW'(pm[a][0]) + PW'(pm[a][1]) + PW'(pm[a][2]);
        sd3[a] <= PW'(pd[a][0]) + PW'(pd[a][1]) + PW'(pd[a][2]);
        v3[a]  <= {er2[a], {(W-1){1'b0}}};
      end

      for (int a = 0; a < N; a++) begin
        sm[a] <= sm3[a];
        sd[a] <= sd3[a];
        v[a]  <= v3[a];
        am[a] <= (sm3[a] < 0) ? -sm3[a] : sm3[a];
        ad[a] <= (sd3[a] < 0) ? -sd3[a] : sd3[a];
      end
    end
  end

endmodule

// ===== rtl/sobb_edge.sv =====
// ----------------------------------------------------------------------------
// sobb_edge
// The edge tests: cross products of the midpoint offset and the half
// vector against their bounds, combined with the face result into the hit.
// Six register stages.
// ----------------------------------------------------------------------------
module sobb_edge #(
  parameter int COORD_WIDTH = 16,
  localparam int PW = sobb_pkg::sum_w(COORD_WIDTH),
  localparam int VW = sobb_pkg::scale_w(COORD_WIDTH)
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic                 face_ok,
  input  logic signed [PW-1:0] sm [sobb_pkg::N_AXES],
  input  logic signed [PW-1:0] sd [sobb_pkg::N_AXES],
  input  logic signed [PW-1:0] ad [sobb_pkg::N_AXES],
  input  logic signed [VW-1:0] v  [sobb_pkg::N_AXES],
  output logic                 hit
);

  localparam int N    = sobb_pkg::N_AXES;
  localparam int XW   = 2 * PW;
  localparam int BPW  = VW + PW;
  localparam int CW   = ((XW > BPW) ? XW : BPW) + 2;
  localparam int FD   = 5;

  logic signed [XW-1:0]  px [N];
  logic signed [XW-1:0]  py [N];
  logic signed [BPW-1:0] bx [N];
  logic signed [BPW-1:0] by [N];

  logic signed [CW-1:0] cr [N];
  logic signed [CW-1:0] bd [N];
  logic signed [CW-1:0] acr [N];
  logic signed [CW-1:0] bd5 [N];
  logic [FD-1:0]        face_d;
  logic                 edge_ok;

  for (genvar k = 0; k < N; k++) begin : g_edge
    sobb_wmul #(.AW(PW), .BW(PW)) u_mul_x (
      .clk (clk),
      .en  (en),
      .a   (sm[sobb_pkg::EDGE_P[k]]),
      .b   (sd[sobb_pkg::EDGE_Q[k]]),
      .p   (px[k])
    );
    sobb_wmul #(.AW(PW), .BW(PW)) u_mul_y (
      .clk (clk),
      .en  (en),
      .a   (sm[sobb_pkg::EDGE_Q[k]]),
      .b   (sd[sobb_pkg::EDGE_P[k]]),
      .p   (py[k])
    );
    sobb_wmul #(.AW(VW), .BW(PW)) u_bnd_x (
      .clk (clk),
      .en  (en),
      .a   (v[sobb_pkg::EDGE_P[k]]),
      .b   (ad[sobb_pkg::EDGE_Q[k]]),
      .p   (bx[k])
    );
    sobb_wmul #(.AW(VW), .BW(PW)) u_bnd_y (
      .clk (clk),
      .en  (en),
      .a   (v[sobb_pkg::EDGE_Q[k]]),
      .b   (ad[sobb_pkg::EDGE_P[k]]),
      .p   (by[k])
    );
  end

  // Equality of distance and bound still counts as a hit.
  always_comb begin
    edge_ok = 1'b1;
    for (int k = 0; k < N; k++) begin
      if (acr[k] > bd5[k]) begin
        edge_ok = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      face_d <= {face_d[FD-2:0], face_ok};
      for (int k = 0; k < N; k++) begin
        cr[k]  <= CW'(px[k]) - CW'(py[k]);
        bd[k]  <= CW'(bx[k]) + CW'(by[k]);
        acr[k] <= (cr[k] < 0) ? -cr[k] : cr[k];
        bd5[k] <= bd[k];
      end
      hit <= face_d[FD-1] & edge_ok;
    end
  end

endmodule

// ===== rtl/segment_obb_overlap.sv =====
// Throughput: one item per cycle; the chain of split wide multipliers in the
// edge tests sets the depth, and every stage takes a new item each cycle unless
// a result is stalled, which holds the whole pipeline until it is taken.
// Reset clears the valid bits of the pipeline only; data registers are not reset.
// ----------------------------------------------------------------------------
// segment_obb_overlap
// Thick segment versus oriented box overlap by separating axes, fully
// pipelined: box-frame transform, face tests, then edge tests.
// ----------------------------------------------------------------------------
module segment_obb_overlap #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            query_valid,
  output logic                            query_stall,
  input  logic [sobb_pkg::FIELD_W-1:0]    seg_start,
  input  logic [sobb_pkg::FIELD_W-1:0]    seg_end,
  input  logic [sobb_pkg::RADIUS_W-1:0]   seg_radius,
  input  logic [sobb_pkg::FIELD_W-1:0]    box_center,
  input  logic [sobb_pkg::FIELD_W-1:0]    box_half_extents,
  input  logic [sobb_pkg::FIELD_W-1:0]    box_axis_x,
  input  logic [sobb_pkg::FIELD_W-1:0]    box_axis_y,
  input  logic [sobb_pkg::FIELD_W-1:0]    box_axis_z,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic                            hit
);

  localparam int N     = sobb_pkg::N_AXES;
  localparam int PW    = sobb_pkg::sum_w(COORD_WIDTH);
  localparam int VW    = sobb_pkg::scale_w(COORD_WIDTH);
  localparam int FW    = ((PW > VW) ? PW : VW) + 2;
  localparam int DEPTH = 10;

  logic              en;
  logic [DEPTH-1:0]  vld;
  logic              face_ok;

  logic signed [PW-1:0] sm [N];
  logic signed [PW-1:0] sd [N];
  logic signed [PW-1:0] am [N];
  logic signed [PW-1:0] ad [N];
  logic signed [VW-1:0] v  [N];

  // The pipeline moves unless a finished item is waiting and not taken.
  assign en           = ~(vld[DEPTH-1] & result_stall);
  assign query_stall  = ~en;
  assign result_valid = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], query_valid};
    end
  end

  sobb_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk              (clk),
    .en               (en),
    .seg_start        (seg_start),
    .seg_end          (seg_end),
    .seg_radius       (seg_radius),
    .box_center       (box_center),
    .box_half_extents (box_half_extents),
    .box_axis_x       (box_axis_x),
    .box_axis_y       (box_axis_y),
    .box_axis_z       (box_axis_z),
    .sm               (sm),
    .sd               (sd),
    .am               (am),
    .ad               (ad),
    .v                (v)
  );

  // Face tests: the projected offset must not exceed extent plus projected
  // half vector on any box axis.
  always_comb begin
    face_ok = 1'b1;
    for (int a = 0; a < N; a++) begin
      if (FW'(am[a]) > FW'(v[a]) + FW'(ad[a])) begin
        face_ok = 1'b0;
      end
    end
  end

  sobb_edge #(.COORD_WIDTH(COORD_WIDTH)) u_edge (
    .clk     (clk),
    .en      (en),
    .face_ok (face_ok),
    .sm      (sm),
    .sd      (sd),
    .ad      (ad),
    .v       (v),
    .hit     (hit)
  );

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the thick segment versus oriented box overlap
// pipeline. Each item sent is scored by a wide-integer separating-axis
// predictor, and every hit bit that comes back is compared in order.
// ----------------------------------------------------------------------------
module testbench;

  localparam int COORD_W      = 16;
  localparam int DUT_LATENCY  = 10;
  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 4000;
  localparam int ONE          = 256;    // 1.0 in Q8.8
  localparam int AX_ONE       = 16384;  // 1.0 in Q2.14
  localparam int AX_DIAG      = 11585;  // 1/sqrt(2) in Q2.14

  typedef logic signed [127:0] wide_t;
  localparam wide_t EXT_SCALE = wide_t'(1) <<< (COORD_W - 1);

  typedef struct {
    logic [sobb_pkg::FIELD_W-1:0]  seg_start;
    logic [sobb_pkg::FIELD_W-1:0]  seg_end;
    logic [sobb_pkg::RADIUS_W-1:0] seg_radius;
    logic [sobb_pkg::FIELD_W-1:0]  box_center;
    logic [sobb_pkg::FIELD_W-1:0]  box_half_extents;
    logic [sobb_pkg::FIELD_W-1:0]  box_axis_x;
    logic [sobb_pkg::FIELD_W-1:0]  box_axis_y;
    logic [sobb_pkg::FIELD_W-1:0]  box_axis_z;
  } query_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          query_valid = 1'b0;
  logic                          query_stall;
  logic [sobb_pkg::FIELD_W-1:0]  seg_start = '0;
  logic [sobb_pkg::FIELD_W-1:0]  seg_end = '0;
  logic [sobb_pkg::RADIUS_W-1:0] seg_radius = '0;
  logic [sobb_pkg::FIELD_W-1:0]  box_center = '0;
  logic [sobb_pkg::FIELD_W-1:0]  box_half_extents = '0;
  logic [sobb_pkg::FIELD_W-1:0]  box_axis_x = '0;
  logic [sobb_pkg::FIELD_W-1:0]  box_axis_y = '0;
  logic [sobb_pkg::FIELD_W-1:0]  box_axis_z = '0;
  logic                          result_valid;
  logic                          result_stall = 1'b0;
  logic                          hit;

  bit expected_hits[$];
  int errors = 0;
  int items_sent = 0;
  int overlaps_seen = 0;
  int separations_seen = 0;
  int stalled_offers = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_request = 1'b0;
  int hold_left = 0;

  segment_obb_overlap #(.COORD_WIDTH(COORD_W)) dut (
    .clk(clk),
    .rst(rst),
    .query_valid(query_valid),
    .query_stall(query_stall),
    .seg_start(seg_start),
    .seg_end(seg_end),
    .seg_radius(seg_radius),
    .box_center(box_center),
    .box_half_extents(box_half_extents),
    .box_axis_x(box_axis_x),
    .box_axis_y(box_axis_y),
    .box_axis_z(box_axis_z),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .hit(hit)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic wide_t coord(input logic [sobb_pkg::FIELD_W-1:0] word, input int i);
    logic signed [COORD_W-1:0] raw;
    raw = word[i*COORD_W +: COORD_W];
    return wide_t'(raw);
  endfunction

  function automatic wide_t wabs(input wide_t v);
    return (v < 0) ? -v : v;
  endfunction

  // Doubled midpoint and doubled half vector keep the factor one half exact;
  // the enlarged extents are scaled to match the projections.
  function automatic bit predict_overlap(input query_t q);
    wide_t mid2[3], half2[3], mproj[3], dproj[3], vext[3];
    wide_t axc, sm, sd, cr, limit_w, rad_w;
    logic [sobb_pkg::FIELD_W-1:0] axw;
    int i, a, k, pi, qi;
    bit overlap;
    overlap = 1'b1;
    rad_w = wide_t'(q.seg_radius);
    for (i = 0; i < 3; i++) begin
      mid2[i]  = coord(q.seg_start, i) + coord(q.seg_end, i) - 2 * coord(q.box_center, i);
      half2[i] = coord(q.seg_end, i) - coord(q.seg_start, i);
    end
    for (a = 0; a < 3; a++) begin
      axw = (a == 0) ? q.box_axis_x : (a == 1) ? q.box_axis_y : q.box_axis_z;
      sm = 0;
      sd = 0;
      for (i = 0; i < 3; i++) begin
        axc = coord(axw, i);
        sm += axc * mid2[i];
        sd += axc * half2[i];
      end
      mproj[a] = sm;
      dproj[a] = sd;
      vext[a]  = (coord(q.box_half_extents, a) + rad_w) * EXT_SCALE;
      if (wabs(sm) > vext[a] + wabs(sd)) overlap = 1'b0;
    end
    for (k = 0; k < 3; k++) begin
      pi = sobb_pkg::EDGE_P[k];
      qi = sobb_pkg::EDGE_Q[k];
      cr = mproj[pi] * dproj[qi] - mproj[qi] * dproj[pi];
      limit_w = vext[pi] * wabs(dproj[qi]) + vext[qi] * wabs(dproj[pi]);
      if (wabs(cr) > limit_w) overlap = 1'b0;
    end
    return overlap;
  endfunction

  // ---------------------------------------------------------------- item builders

  function automatic logic [sobb_pkg::FIELD_W-1:0] pack3(input int x, input int y, input int z);
    return {z[15:0], y[15:0], x[15:0]};
  endfunction

  function automatic logic [sobb_pkg::FIELD_W-1:0] rand48();
    return sobb_pkg::FIELD_W'({$urandom, $urandom});
  endfunction

  function automatic int srand(input int lo, input int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic int axis_q14(input real v);
    return int'(v * 16384.0);
  endfunction

  function automatic query_t scene(
    input logic [sobb_pkg::FIELD_W-1:0] s, input logic [sobb_pkg::FIELD_W-1:0] e,
    input int rad, input logic [sobb_pkg::FIELD_W-1:0] c,
    input logic [sobb_pkg::FIELD_W-1:0] ext, input logic [sobb_pkg::FIELD_W-1:0] ax,
    input logic [sobb_pkg::FIELD_W-1:0] ay, input logic [sobb_pkg::FIELD_W-1:0] az);
    query_t q;
    q.seg_start = s;
    q.seg_end = e;
    q.seg_radius = rad[sobb_pkg::RADIUS_W-1:0];
    q.box_center = c;
    q.box_half_extents = ext;
    q.box_axis_x = ax;
    q.box_axis_y = ay;
    q.box_axis_z = az;
    return q;
  endfunction

  // A rotated box with a segment placed near it, so that overlaps and
  // separations both come up often.
  function automatic query_t make_scene();
    real yaw, tilt, ca, sa, cb, sb;
    int ext[3], cen[3], off[3], hv[3], st[3], en[3];
    int rad, i, span;
    query_t q;
    if ($urandom_range(3) == 0) begin
      yaw = 0.0;
      tilt = 0.0;
    end else begin
      yaw = $urandom_range(62831) / 10000.0;
      tilt = $urandom_range(62831) / 10000.0;
    end
    ca = $cos(yaw);
    sa = $sin(yaw);
    cb = $cos(tilt);
    sb = $sin(tilt);
    rad = ($urandom_range(3) == 0) ? 0 : $urandom_range(512);
    for (i = 0; i < 3; i++) begin
      ext[i] = $urandom_range(2048, 16);
      span = ext[i] + rad + 1024;
      cen[i] = srand(-10240, 10240);
      off[i] = srand(-span, span);
      hv[i] = ($urandom_range(7) == 0) ? 0 : srand(-1536, 1536);
      st[i] = cen[i] + off[i] - hv[i];
      en[i] = cen[i] + off[i] + hv[i];
    end
    q.seg_start = pack3(st[0], st[1], st[2]);
    q.seg_end = pack3(en[0], en[1], en[2]);
    q.seg_radius = rad[sobb_pkg::RADIUS_W-1:0];
    q.box_center = pack3(cen[0], cen[1], cen[2]);
    q.box_half_extents = pack3(ext[0], ext[1], ext[2]);
    q.box_axis_x = pack3(axis_q14(ca), axis_q14(sa), 0);
    q.box_axis_y = pack3(axis_q14(-sa * cb), axis_q14(ca * cb), axis_q14(sb));
    q.box_axis_z = pack3(axis_q14(sa * sb), axis_q14(-ca * sb), axis_q14(cb));
    return q;
  endfunction

  function automatic query_t random_query();
    int pick;
    query_t q;
    pick = $urandom_range(99);
    if (pick < 15) begin
      q = scene(rand48(), rand48(), $urandom_range(32767), rand48(), rand48(),
                rand48(), rand48(), rand48());
    end else begin
      q = make_scene();
      if (pick < 20) q.box_axis_y = rand48();
      else if (pick < 25) q.box_half_extents = pack3(srand(-512, 256), srand(-512, 256),
                                                     srand(-512, 256));
    end
    return q;
  endfunction

  // ---------------------------------------------------------------- handshake

  task automatic send_query(input query_t q);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      query_valid <= 1'b0;
      @(negedge clk);
    end
    query_valid <= 1'b1;
    seg_start <= q.seg_start;
    seg_end <= q.seg_end;
    seg_radius <= q.seg_radius;
    box_center <= q.box_center;
    box_half_extents <= q.box_half_extents;
    box_axis_x <= q.box_axis_x;
    box_axis_y <= q.box_axis_y;
    box_axis_z <= q.box_axis_z;
    @(posedge clk);
    while (query_stall) @(posedge clk);
    expected_hits.push_back(predict_overlap(q));
    items_sent++;
  endtask

  task automatic wait_drain();
    @(negedge clk);
    query_valid <= 1'b0;
    while (expected_hits.size() != 0) @(posedge clk);
  endtask

  always @(negedge clk) begin
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (query_valid && query_stall) stalled_offers++;
      if (result_valid && !result_stall) begin
        if (expected_hits.size() == 0) begin
          $error("result with no item outstanding: hit=%0b", hit);
          errors++;
        end else begin
          if (hit !== expected_hits[0]) begin
            $error("field hit mismatch: expected %0b, actual %0b", expected_hits[0], hit);
            errors++;
          end
          if (expected_hits[0]) overlaps_seen++;
          else separations_seen++;
          void'(expected_hits.pop_front());
        end
      end
    end
  end

  // Ends the run if the pipeline stops moving in both directions.
  always @(posedge clk) begin
    if ((query_valid && !query_stall) || (result_valid && !result_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Timeout: nothing moved for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, expected_hits.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_field_extremes();
    logic [sobb_pkg::FIELD_W-1:0] p, n, a5, aa;
    p = pack3(32767, 32767, 32767);
    n = pack3(-32768, -32768, -32768);
    a5 = 48'h5555_5555_5555;
    aa = 48'hAAAA_AAAA_AAAA;
    send_query(scene('0, '0, 0, '0, '0, '0, '0, '0));
    send_query(scene('1, '1, 32767, '1, '1, '1, '1, '1));
    send_query(scene(p, p, 32767, p, p, p, p, p));
    send_query(scene(n, n, 0, n, n, n, n, n));
    send_query(scene(p, n, 32767, n, p, p, n, p));
    send_query(scene(a5, aa, 21845, aa, a5, aa, a5, aa));
    wait_drain();
  endtask

  // Identity box of unit half size: points exactly on a face or on the grown
  // face must count as overlap, one step further out must not.
  task automatic test_boundary_ties();
    logic [sobb_pkg::FIELD_W-1:0] ix, iy, iz, e1;
    ix = pack3(AX_ONE, 0, 0);
    iy = pack3(0, AX_ONE, 0);
    iz = pack3(0, 0, AX_ONE);
    e1 = pack3(ONE, ONE, ONE);
    send_query(scene(pack3(-128, 0, 0), pack3(128, 0, 0), 0, '0, e1, ix, iy, iz));
    send_query(scene(pack3(768, 0, 0), pack3(1024, 0, 0), 0, '0, e1, ix, iy, iz));
    send_query(scene(pack3(ONE, 0, 0), pack3(ONE, 0, 0), 0, '0, e1, ix, iy, iz));
    send_query(scene(pack3(ONE + 1, 0, 0), pack3(ONE + 1, 0, 0), 0, '0, e1, ix, iy, iz));
    send_query(scene(pack3(384, 0, 0), pack3(384, 0, 0), 128, '0, e1, ix, iy, iz));
    send_query(scene(pack3(384, 0, 0), pack3(384, 0, 0), 127, '0, e1, ix, iy, iz));
    send_query(scene(pack3(0, -ONE, 0), pack3(0, -ONE, 0), 0, '0, e1, ix, iy, iz));
    wait_drain();
  endtask

  // Segments beside an edge of the box; all but the last clear every face test.
  task automatic test_edge_axis_separation();
    logic [sobb_pkg::FIELD_W-1:0] ix, iy, iz, e1, rx, ry;
    ix = pack3(AX_ONE, 0, 0);
    iy = pack3(0, AX_ONE, 0);
    iz = pack3(0, 0, AX_ONE);
    e1 = pack3(ONE, ONE, ONE);
    rx = pack3(AX_DIAG, AX_DIAG, 0);
    ry = pack3(-AX_DIAG, AX_DIAG, 0);
    send_query(scene(pack3(128, 640, 0), pack3(640, 128, 0), 0, '0, e1, ix, iy, iz));
    send_query(scene(pack3(128, 640, 0), pack3(640, 128, 0), 128, '0, e1, ix, iy, iz));
    send_query(scene(pack3(0, 128, 640), pack3(0, 640, 128), 0, '0, e1, ix, iy, iz));
    send_query(scene(pack3(384, 0, 128), pack3(384, 640, 640), 0, '0, e1, rx, ry, iz));
    wait_drain();
  endtask

  task automatic test_degenerate_boxes();
    logic [sobb_pkg::FIELD_W-1:0] ix, iy, iz, e1, big;
    ix = pack3(AX_ONE, 0, 0);
    iy = pack3(0, AX_ONE, 0);
    iz = pack3(0, 0, AX_ONE);
    e1 = pack3(ONE, ONE, ONE);
    big = pack3(32767, 32767, 32767);
    send_query(scene('0, '0, 384, '0, pack3(-ONE, -ONE, -ONE), ix, iy, iz));
    send_query(scene('0, '0, 0, '0, pack3(-ONE, -ONE, -ONE), ix, iy, iz));
    send_query(scene(pack3(5000, 5000, 5000), pack3(6000, 6000, 6000), 0, '0, e1,
                     '0, '0, '0));
    send_query(scene(pack3(64, 0, 0), pack3(64, 32, 0), 0, '0, e1, big, big, big));
    send_query(scene(pack3(ONE + 1, 0, 0), pack3(ONE + 1, 0, 0), 0, '0,
                     pack3(ONE + 1, 1, 3), ix, iy, iz));
    send_query(scene(pack3(100, -200, 300), pack3(100, -200, 300), 0,
                     pack3(100, -200, 300), e1, ix, iy, iz));
    send_query(scene(pack3(-25600, 128, 128), pack3(25600, 128, 128), 0, '0, e1,
                     ix, iy, iz));
    wait_drain();
  endtask

  task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct);
    int n;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    for (n = 0; n < count; n++) send_query(random_query());
    wait_drain();
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  // The receiver holds off while items keep coming, so the pipeline fills and
  // pushes back on the input.
  task automatic test_output_hold();
    int n;
    hold_request = 1'b1;
    for (n = 0; n < 40; n++) send_query(random_query());
    wait_drain();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_field_extremes();
    test_boundary_ties();
    test_edge_axis_separation();
    test_degenerate_boxes();
    test_random_traffic(330, 0, 0);
    test_random_traffic(330, 81, 0);
    test_random_traffic(330, 0, 81);
    test_random_traffic(330, 31, 31);
    test_output_hold();
    repeat (2 * DUT_LATENCY) @(posedge clk);
    if (expected_hits.size() != 0) begin
      $error("%0d results never arrived", expected_hits.size());
      errors++;
    end
    $display("Sent %0d queries: %0d came back overlapping, %0d separated, %0d errors.",
             items_sent, overlaps_seen, separations_seen, errors);
    $display("Ties, edge axes, degenerate boxes, four idle mixes and a %0d-cycle hold %s",
             HOLD_CYCLES, $sformatf("(%0d stalled offers).", stalled_offers));
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/sobb_pkg.sv
rtl/sobb_wmul.sv
rtl/sobb_front.sv
rtl/sobb_edge.sv
rtl/segment_obb_overlap.sv
bench/testbench.sv
